### rtl/fbmm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbmm_pkg
// Shared types and codes for the frame buffer mailbox manager.
// ----------------------------------------------------------------------------
package fbmm_pkg;

   localparam int KIND_W    = 2;
   localparam int DISPLAY_W = 4;
   localparam int STATUS_W  = 3;
   localparam int SERVED_W  = 2;
   localparam int INDEX_W   = 2;

   localparam logic [KIND_W-1:0] KIND_ACQUIRE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PRESENT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CONSUME = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK           = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_FREE_EMPTY   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_HELD         = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_ACQUIRED = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_BAD_DISPLAY  = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_NO_FRAME     = 3'd5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_FETCH
   } state_type;

endpackage
`default_nettype wire

### rtl/frame_buffer_mailbox_manager_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frame_buffer_mailbox_manager_core
// Per-display buffer mailbox: free list, acquired slot and present slot.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its result shows on
// the rsp_ ports for exactly one cycle with rsp_valid high, and the receiver
// cannot stall it. Present, consume and a refused acquire pass through the read
// state only, and a granted acquire also passes through the fetch state: every
// command reads the display record memory once, and a granted acquire then
// reads the free-list memory for the popped index. Both memories start in
// their reset contents through per-entry valid bits, so no clearing pass runs
// after reset.
// ----------------------------------------------------------------------------
module frame_buffer_mailbox_manager_core
   import fbmm_pkg::*;
#(
   parameter int NUM_DISPLAYS        = 4,
   parameter int BUFFERS_PER_DISPLAY = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [KIND_W-1:0]    req_kind,
   input  wire logic [DISPLAY_W-1:0] req_display,
   output logic                      rsp_valid,
   output logic      [STATUS_W-1:0]  rsp_status,
   output logic      [SERVED_W-1:0]  rsp_served_display,
   output logic      [INDEX_W-1:0]   rsp_frame_index,
   output logic                      rsp_dropped,
   output logic      [INDEX_W-1:0]   rsp_dropped_index
);

   localparam int DW       = (NUM_DISPLAYS > 1) ? $clog2(NUM_DISPLAYS) : 1;
   localparam int BW       = $clog2(BUFFERS_PER_DISPLAY);
   localparam int CW       = $clog2(BUFFERS_PER_DISPLAY + 1);
   localparam int FL_DEPTH = NUM_DISPLAYS * BUFFERS_PER_DISPLAY;
   localparam int FLA_W    = $clog2(FL_DEPTH);

   typedef struct packed {
      logic [BW-1:0] head;
      logic [CW-1:0] count;
      logic          acq_valid;
      logic [BW-1:0] acq_slot;
      logic [BW-1:0] pres_slot;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   localparam rec_type REC_RESET = '{
      head:      '0,
      count:     CW'(BUFFERS_PER_DISPLAY),
      acq_valid: 1'b0,
      acq_slot:  '0,
      pres_slot: '0
   };

   function automatic logic [FLA_W-1:0] fl_addr(input logic [DW-1:0] d,
                                                 input logic [BW-1:0] p);
      fl_addr = FLA_W'(int'(d) * BUFFERS_PER_DISPLAY + int'(p));
   endfunction

   function automatic logic [BW-1:0] fl_tail(input logic [BW-1:0] h,
                                              input logic [CW-1:0] c);
      logic [CW:0] sum;
      sum = (CW + 1)'(h) + (CW + 1)'(c);
      if (sum >= (CW + 1)'(BUFFERS_PER_DISPLAY)) begin
         sum = sum - (CW + 1)'(BUFFERS_PER_DISPLAY);
      end
      fl_tail = sum[BW-1:0];
   endfunction

   state_type state_ff, state_in;

   logic                    accept;
   logic                    consume_ff;
   logic                    acquire_ff;
   logic                    bad_ff;
   logic                    found_ff;
   logic [DW-1:0]           tgt_ff;
   logic [DW-1:0]           tgt;
   logic                    rec_ok_ff;
   logic                    fl_ok_ff;
   logic [BW-1:0]           fl_pos_ff;
   logic [DW-1:0]           scan_ptr_ff, scan_ptr_in;
   logic [NUM_DISPLAYS-1:0] pres_valid_ff;
   logic [NUM_DISPLAYS-1:0] rec_valid_ff;
   logic [FL_DEPTH-1:0]     fl_valid_ff;

   logic          scan_found;
   logic [DW-1:0] scan_index;

   logic [REC_W-1:0] rec_rd_data;
   rec_type          rec_cur;
   logic             rec_wr_en;
   rec_type          rec_wr_data;

   logic             fl_wr_en;
   logic [FLA_W-1:0] fl_wr_addr;
   logic [BW-1:0]    fl_wr_data;
   logic             fl_rd_en;
   logic [FLA_W-1:0] fl_rd_addr;
   logic [BW-1:0]    fl_rd_data;
   logic [BW-1:0]    fl_value;

   logic pres_set;
   logic pres_clr;
   logic acq_go;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SERVED_W-1:0] rsp_served_ff, rsp_served_in;
   logic [INDEX_W-1:0]  rsp_bidx_ff, rsp_bidx_in;
   logic                rsp_drop_ff, rsp_drop_in;
   logic [INDEX_W-1:0]  rsp_didx_ff, rsp_didx_in;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && (state_ff == ST_IDLE);

   fbmm_scan #(
      .NUM_DISPLAYS(NUM_DISPLAYS)
   ) u_scan (
      .present_valid(pres_valid_ff),
      .scan_ptr     (scan_ptr_ff),
      .found        (scan_found),
      .index        (scan_index)
   );

   assign tgt = req_kind[1] ? scan_index : req_display[DW-1:0];

   fbmm_ram #(
      .WIDTH(REC_W),
      .DEPTH(NUM_DISPLAYS)
   ) u_rec_ram (
      .clock     (clock),
      .wr_en     (rec_wr_en),
      .wr_addr   (tgt_ff),
      .wr_data   (rec_wr_data),
      .rd_en     (accept),
      .rd_addr   (tgt),
      .rd_data_ff(rec_rd_data)
   );

   fbmm_ram #(
      .WIDTH(BW),
      .DEPTH(FL_DEPTH)
   ) u_fl_ram (
      .clock     (clock),
      .wr_en     (fl_wr_en),
      .wr_addr   (fl_wr_addr),
      .wr_data   (fl_wr_data),
      .rd_en     (fl_rd_en),
      .rd_addr   (fl_rd_addr),
      .rd_data_ff(fl_rd_data)
   );

   assign rec_cur  = rec_ok_ff ? rec_type'(rec_rd_data) : REC_RESET;
   assign fl_value = fl_ok_ff ? fl_rd_data : fl_pos_ff;
   assign acq_go   = acquire_ff && !bad_ff && (rec_cur.count != '0) && !rec_cur.acq_valid;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = acq_go ? ST_FETCH : ST_IDLE;
         end
         ST_FETCH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rec_wr_en     = 1'b0;
      rec_wr_data   = rec_cur;
      fl_wr_en      = 1'b0;
      fl_wr_addr    = fl_addr(tgt_ff, fl_tail(rec_cur.head, rec_cur.count));
      fl_wr_data    = rec_cur.pres_slot;
      fl_rd_en      = 1'b0;
      fl_rd_addr    = fl_addr(tgt_ff, rec_cur.head);
      pres_set      = 1'b0;
      pres_clr      = 1'b0;
      scan_ptr_in   = scan_ptr_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = STATUS_OK;
      rsp_served_in = '0;
      rsp_bidx_in   = '0;
      rsp_drop_in   = 1'b0;
      rsp_didx_in   = '0;
      unique case (state_ff)
         ST_READ: begin
            if (consume_ff) begin
               rsp_valid_in = 1'b1;
               if (!found_ff) begin
                  rsp_status_in = STATUS_NO_FRAME;
               end else begin
                  rsp_served_in = SERVED_W'(tgt_ff);
                  rsp_bidx_in   = INDEX_W'(rec_cur.pres_slot);
                  pres_clr      = 1'b1;
                  scan_ptr_in   = tgt_ff;
                  if (rec_cur.count < CW'(BUFFERS_PER_DISPLAY)) begin
                     fl_wr_en          = 1'b1;
                     rec_wr_en         = 1'b1;
                     rec_wr_data.count = rec_cur.count + CW'(1);
                  end
               end
            end else if (bad_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_BAD_DISPLAY;
            end else if (acquire_ff) begin
               rsp_served_in = SERVED_W'(tgt_ff);
               if (rec_cur.count == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_FREE_EMPTY;
               end else if (rec_cur.acq_valid) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_HELD;
               end else begin
                  fl_rd_en = 1'b1;
               end
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_served_in = SERVED_W'(tgt_ff);
               if (!rec_cur.acq_valid) begin
                  rsp_status_in = STATUS_NOT_ACQUIRED;
               end else begin
                  rsp_bidx_in           = INDEX_W'(rec_cur.acq_slot);
                  rec_wr_en             = 1'b1;
                  rec_wr_data.acq_valid = 1'b0;
                  rec_wr_data.acq_slot  = '0;
                  rec_wr_data.pres_slot = rec_cur.acq_slot;
                  pres_set              = 1'b1;
                  if (pres_valid_ff[tgt_ff]) begin
                     rsp_drop_in = 1'b1;
                     rsp_didx_in = INDEX_W'(rec_cur.pres_slot);
                     if (rec_cur.count < CW'(BUFFERS_PER_DISPLAY)) begin
                        fl_wr_en          = 1'b1;
                        rec_wr_data.count = rec_cur.count + CW'(1);
                     end
                  end
               end
            end
         end
         ST_FETCH: begin
            rsp_valid_in          = 1'b1;
            rsp_served_in         = SERVED_W'(tgt_ff);
            rsp_bidx_in           = INDEX_W'(fl_value);
            rec_wr_en             = 1'b1;
            rec_wr_data.acq_valid = 1'b1;
            rec_wr_data.acq_slot  = fl_value;
            rec_wr_data.count     = rec_cur.count - CW'(1);
            rec_wr_data.head      = (rec_cur.head == BW'(BUFFERS_PER_DISPLAY - 1)) ?
                                    '0 : rec_cur.head + BW'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         scan_ptr_ff   <= '0;
         pres_valid_ff <= '0;
         rec_valid_ff  <= '0;
         fl_valid_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ptr_ff  <= scan_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (pres_set) begin
            pres_valid_ff[tgt_ff] <= 1'b1;
         end else if (pres_clr) begin
            pres_valid_ff[tgt_ff] <= 1'b0;
         end
         if (rec_wr_en) begin
            rec_valid_ff[tgt_ff] <= 1'b1;
         end
         if (fl_wr_en) begin
            fl_valid_ff[fl_wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         consume_ff <= req_kind[1];
         acquire_ff <= (req_kind == KIND_ACQUIRE);
         bad_ff     <= (32'(req_display) >= NUM_DISPLAYS);
         found_ff   <= scan_found;
         tgt_ff     <= tgt;
         rec_ok_ff  <= rec_valid_ff[tgt];
      end
      if (fl_rd_en) begin
         fl_ok_ff  <= fl_valid_ff[fl_rd_addr];
         fl_pos_ff <= rec_cur.head;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_served_ff <= rsp_served_in;
      rsp_bidx_ff   <= rsp_bidx_in;
      rsp_drop_ff   <= rsp_drop_in;
      rsp_didx_ff   <= rsp_didx_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_served_display = rsp_served_ff;
   assign rsp_frame_index    = rsp_bidx_ff;
   assign rsp_dropped        = rsp_drop_ff;
   assign rsp_dropped_index  = rsp_didx_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("Accepted transfer did not raise busy.");

   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == ST_IDLE))
      else $error("Result strobe while a command is still in progress.");

   a_fetch_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH) |-> ($past(state_ff) == ST_READ))
      else $error("Free-list fetch without a preceding record read.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rec_wr_en |-> (rec_wr_data.count <= CW'(BUFFERS_PER_DISPLAY)))
      else $error("Free-list count exceeds the buffer count.");

   a_drop_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dropped |-> (rsp_status == STATUS_OK))
      else $error("Dropped frame reported on a failed command.");

endmodule
`default_nettype wire

### rtl/fbmm_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbmm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fbmm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

### rtl/fbmm_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbmm_scan
// Round-robin search for the first display with a presented frame,
// starting at the scan pointer.
// ----------------------------------------------------------------------------
module fbmm_scan
   import fbmm_pkg::*;
#(
   parameter int NUM_DISPLAYS = 4,
   localparam int DW = (NUM_DISPLAYS > 1) ? $clog2(NUM_DISPLAYS) : 1
) (
   input  wire logic [NUM_DISPLAYS-1:0] present_valid,
   input  wire logic [DW-1:0]           scan_ptr,
   output logic                         found,
   output logic      [DW-1:0]           index
);

   always_comb begin
      logic [DW:0] pos;
      found = 1'b0;
      index = '0;
      for (int off = NUM_DISPLAYS - 1; off >= 0; off--) begin
         pos = (DW + 1)'(scan_ptr) + (DW + 1)'(off);
         if (pos >= (DW + 1)'(NUM_DISPLAYS)) begin
            pos = pos - (DW + 1)'(NUM_DISPLAYS);
         end
         if (present_valid[pos[DW-1:0]]) begin
            found = 1'b1;
            index = pos[DW-1:0];
         end
      end
   end

endmodule
`default_nettype wire

### verif/frame_buffer_mailbox_manager_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_buffer_mailbox_manager_checker
// Watches the command and result channels of the mailbox manager. It keeps
// its own copy of every display's free list, acquired slot and present slot,
// predicts the result of each accepted command and compares every result
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module frame_buffer_mailbox_manager_checker
   import fbmm_pkg::*;
#(
   parameter int NUM_DISPLAYS        = 4,
   parameter int BUFFERS_PER_DISPLAY = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic                 busy,
   input  wire logic [KIND_W-1:0]    req_kind,
   input  wire logic [DISPLAY_W-1:0] req_display,
   input  wire logic                 rsp_valid,
   input  wire logic [STATUS_W-1:0]  rsp_status,
   input  wire logic [SERVED_W-1:0]  rsp_served_display,
   input  wire logic [INDEX_W-1:0]   rsp_frame_index,
   input  wire logic                 rsp_dropped,
   input  wire logic [INDEX_W-1:0]   rsp_dropped_index,
   output int                        failures,
   output int                        pending
);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SERVED_W-1:0] served;
      logic [INDEX_W-1:0]  index;
      logic                dropped;
      logic [INDEX_W-1:0]  dropped_index;
   } reply_type;

   logic [INDEX_W-1:0] free_store [NUM_DISPLAYS][BUFFERS_PER_DISPLAY];
   int                 free_head  [NUM_DISPLAYS];
   int                 free_count [NUM_DISPLAYS];
   logic               held_valid [NUM_DISPLAYS];
   logic [INDEX_W-1:0] held_slot  [NUM_DISPLAYS];
   logic               ready_valid[NUM_DISPLAYS];
   logic [INDEX_W-1:0] ready_slot [NUM_DISPLAYS];
   int                 scan_ptr;
   reply_type          expected_replies[$];

   function automatic void return_buffer(input int d, input logic [INDEX_W-1:0] idx);
      if (free_count[d] < BUFFERS_PER_DISPLAY) begin
         free_store[d][(free_head[d] + free_count[d]) % BUFFERS_PER_DISPLAY] = idx;
         free_count[d]++;
      end
   endfunction

   function automatic reply_type predict_swap(input logic [KIND_W-1:0] kind,
                                              input logic [DISPLAY_W-1:0] disp);
      reply_type r;
      int        p;
      int        d;
      int        i;
      bit        found;
      r = '0;
      if (kind >= KIND_CONSUME) begin
         p = (scan_ptr >= NUM_DISPLAYS) ? 0 : scan_ptr;
         found = 0;
         for (i = 0; i < NUM_DISPLAYS && !found; i++) begin
            if (ready_valid[p]) begin
               r.index = ready_slot[p];
               r.served = p[SERVED_W-1:0];
               ready_valid[p] = 1'b0;
               ready_slot[p] = '0;
               return_buffer(p, r.index);
               found = 1;
            end else begin
               p = (p + 1 >= NUM_DISPLAYS) ? 0 : p + 1;
            end
         end
         if (found) scan_ptr = p;
         else r.status = STATUS_NO_FRAME;
      end else if (disp >= NUM_DISPLAYS) begin
         r.status = STATUS_BAD_DISPLAY;
      end else begin
         d = int'(disp);
         r.served = d[SERVED_W-1:0];
         if (kind == KIND_ACQUIRE) begin
            if (free_count[d] == 0) begin
               r.status = STATUS_FREE_EMPTY;
            end else if (held_valid[d]) begin
               r.status = STATUS_HELD;
            end else begin
               r.index = free_store[d][free_head[d]];
               free_head[d] = (free_head[d] + 1) % BUFFERS_PER_DISPLAY;
               free_count[d]--;
               held_valid[d] = 1'b1;
               held_slot[d] = r.index;
            end
         end else begin
            if (!held_valid[d]) begin
               r.status = STATUS_NOT_ACQUIRED;
            end else begin
               if (ready_valid[d]) begin
                  r.dropped = 1'b1;
                  r.dropped_index = ready_slot[d];
                  return_buffer(d, ready_slot[d]);
               end
               r.index = held_slot[d];
               ready_valid[d] = 1'b1;
               ready_slot[d] = held_slot[d];
               held_valid[d] = 1'b0;
               held_slot[d] = '0;
            end
         end
      end
      return r;
   endfunction

   function automatic void check_field(input string name, input int exp, input int act);
      if (exp != act) begin
         $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, exp, act);
         failures++;
      end
   endfunction

   initial begin
      failures = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      reply_type exp;
      if (reset) begin
         for (int d = 0; d < NUM_DISPLAYS; d++) begin
            for (int i = 0; i < BUFFERS_PER_DISPLAY; i++) free_store[d][i] = i[INDEX_W-1:0];
            free_head[d] = 0;
            free_count[d] = BUFFERS_PER_DISPLAY;
            held_valid[d] = 1'b0;
            held_slot[d] = '0;
            ready_valid[d] = 1'b0;
            ready_slot[d] = '0;
         end
         scan_ptr = 0;
         expected_replies.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_replies.size() == 0) begin
               $display("%0t: result with nothing expected: status %0d, display %0d, index %0d",
                        $time, rsp_status, rsp_served_display, rsp_frame_index);
               failures++;
            end else begin
               exp = expected_replies[0];
               expected_replies.delete(0);
               check_field("status", int'(exp.status), int'(rsp_status));
               check_field("served_display", int'(exp.served), int'(rsp_served_display));
               check_field("frame_index", int'(exp.index), int'(rsp_frame_index));
               check_field("dropped", int'(exp.dropped), int'(rsp_dropped));
               check_field("dropped_index", int'(exp.dropped_index),
                           int'(rsp_dropped_index));
            end
         end
         if (start && !busy) begin
            expected_replies.insert(expected_replies.size(),
                                    predict_swap(req_kind, req_display));
         end
      end
      pending = expected_replies.size();
   end

endmodule

### verif/tb_frame_buffer_mailbox_manager_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_frame_buffer_mailbox_manager_core
// Drives acquire, present and consume commands into the mailbox manager.
// A directed opening covers every command, every error answer but free-empty
// and the round-robin scan; random commands with random gaps follow. The checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_frame_buffer_mailbox_manager_core;
   import fbmm_pkg::*;

   localparam int NUM_DISPLAYS        = 4;
   localparam int BUFFERS_PER_DISPLAY = 4;
   localparam int RANDOM_COMMANDS     = 400;
   localparam int LIMIT_CYCLES        = 100000;
   localparam int DRAIN_CYCLES        = 8;
   localparam logic [KIND_W-1:0] KIND_UNUSED = KIND_CONSUME | KIND_PRESENT;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [KIND_W-1:0]    req_kind;
   logic [DISPLAY_W-1:0] req_display;
   logic                 rsp_valid;
   logic [STATUS_W-1:0]  rsp_status;
   logic [SERVED_W-1:0]  rsp_served_display;
   logic [INDEX_W-1:0]   rsp_frame_index;
   logic                 rsp_dropped;
   logic [INDEX_W-1:0]   rsp_dropped_index;
   int                   failures;
   int                   pending;
   int                   cycle_count;
   bit                   no_idle;

   frame_buffer_mailbox_manager_core #(
      .NUM_DISPLAYS       (NUM_DISPLAYS),
      .BUFFERS_PER_DISPLAY(BUFFERS_PER_DISPLAY)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_display       (req_display),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_served_display(rsp_served_display),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_dropped       (rsp_dropped),
      .rsp_dropped_index (rsp_dropped_index)
   );

   frame_buffer_mailbox_manager_checker #(
      .NUM_DISPLAYS       (NUM_DISPLAYS),
      .BUFFERS_PER_DISPLAY(BUFFERS_PER_DISPLAY)
   ) u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_display       (req_display),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_served_display(rsp_served_display),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_dropped       (rsp_dropped),
      .rsp_dropped_index (rsp_dropped_index),
      .failures          (failures),
      .pending           (pending)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 25);
   endfunction

   // One transfer: optional idle cycles, then start held until busy is low.
   task automatic issue(input logic [KIND_W-1:0] kind, input logic [DISPLAY_W-1:0] disp);
      int gap;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start <= 1'b1;
      req_kind <= kind;
      req_display <= disp;
      do @(posedge clock); while (busy);
   endtask

   initial begin
      int                   roll;
      logic [KIND_W-1:0]    kind;
      logic [DISPLAY_W-1:0] disp;
      cycle_count = 0;
      no_idle = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_kind = KIND_ACQUIRE;
      req_display = '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      issue(KIND_ACQUIRE, 4'd0);
      issue(KIND_ACQUIRE, 4'd0);
      issue(KIND_PRESENT, 4'd1);
      issue(KIND_PRESENT, 4'd0);
      issue(KIND_ACQUIRE, 4'd0);
      issue(KIND_PRESENT, 4'd0);
      issue(KIND_ACQUIRE, 4'd0);
      issue(KIND_PRESENT, 4'd0);
      issue(KIND_ACQUIRE, 4'd0);
      issue(KIND_PRESENT, 4'd0);
      issue(KIND_ACQUIRE, 4'd0);
      issue(KIND_CONSUME, 4'd15);
      issue(KIND_CONSUME, 4'd0);
      issue(KIND_ACQUIRE, 4'd15);
      issue(KIND_PRESENT, 4'd4);
      issue(KIND_ACQUIRE, 4'd3);
      issue(KIND_PRESENT, 4'd3);
      issue(KIND_ACQUIRE, 4'd2);
      issue(KIND_PRESENT, 4'd2);
      issue(KIND_UNUSED, 4'd9);
      issue(KIND_CONSUME, 4'd6);
      issue(KIND_CONSUME, 4'd3);
      issue(KIND_PRESENT, 4'd0);
      issue(KIND_CONSUME, 4'd1);

      for (int n = 0; n < RANDOM_COMMANDS; n++) begin
         if (n % 40 == 0) no_idle = ($urandom_range(0, 2) == 0);
         roll = $urandom_range(0, 99);
         if (roll < 38) kind = KIND_ACQUIRE;
         else if (roll < 76) kind = KIND_PRESENT;
         else if (roll < 95) kind = KIND_CONSUME;
         else kind = KIND_UNUSED;
         if (kind >= KIND_CONSUME || $urandom_range(0, 99) >= 85)
            disp = DISPLAY_W'($urandom_range(0, 15));
         else
            disp = DISPLAY_W'($urandom_range(0, NUM_DISPLAYS - 1));
         issue(kind, disp);
      end

      @(negedge clock);
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
